// ===== rtl/fpst_pkg.sv =====
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared widths, request codes, walker state and control types for the
// binary indexed prefix-sum tree.
// ----------------------------------------------------------------------------
`default_nettype none

package fpst_pkg;

	localparam int SIZE_DEF = 4096;
	localparam int POS_W    = 13;
	localparam int DELTA_W  = 16;
	localparam int SUM_W    = 32;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

	// walker -> datapath control
	typedef struct packed {
		logic clr_we;    // clearing pass writes zero
		logic proc_s1;   // read data of one node is valid this cycle
		logic is_query;  // current request is a prefix query
		logic fin;       // walk over, last node already handled
	} walk_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fpst_ram.sv =====
// ----------------------------------------------------------------------------
// fpst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fpst_walk.sv =====
// ----------------------------------------------------------------------------
// fpst_walk
// Sequencer: clearing pass after reset, then per request a node walk
// (upward for updates, downward for queries), one node read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_walk #(
	parameter int SIZE = fpst_pkg::SIZE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         req_type,
	input  wire logic [fpst_pkg::POS_W-1:0]   position,
	output logic                              busy,
	output logic                              rd_en,
	output logic      [$clog2(SIZE)-1:0]      rd_addr,
	output logic      [$clog2(SIZE)-1:0]      wr_addr,
	output fpst_pkg::walk_ctl_t               ctl
);

	import fpst_pkg::*;

	localparam int AW = $clog2(SIZE);
	// node number must hold the position and anything up to twice SIZE
	localparam int NW = (AW + 2 > POS_W + 1) ? AW + 2 : POS_W + 1;

	state_t         state_q;
	logic [NW-1:0]  j_q;
	logic           is_query_q;
	logic           proc_s1;
	logic [AW-1:0]  addr_s1;
	logic [AW-1:0]  clr_q;

	logic [NW-1:0]  pos_ext;
	logic [NW-1:0]  lowbit;
	logic [NW-1:0]  node_m1;
	logic           active;
	logic           fin;

	assign pos_ext = {{(NW-POS_W){1'b0}}, position};
	assign lowbit  = j_q & (~j_q + NW'(1));
	assign node_m1 = j_q - NW'(1);
	assign active  = (j_q != '0) && (j_q <= NW'(SIZE));
	assign fin     = (state_q == ST_WALK) && !active && !proc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			j_q        <= '0;
			is_query_q <= 1'b0;
			proc_s1    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					proc_s1 <= 1'b0;
					if (start) begin
						is_query_q <= req_type;
						// queries past the end cover the whole tree
						if (req_type == REQ_QUERY && pos_ext > NW'(SIZE)) begin
							j_q <= NW'(SIZE);
						end else begin
							j_q <= pos_ext;
						end
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					proc_s1 <= active;
					if (active) begin
						j_q <= is_query_q ? (j_q - lowbit) : (j_q + lowbit);
					end
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= node_m1[AW-1:0];
	end

	assign busy         = (state_q != ST_IDLE);
	assign rd_en        = (state_q == ST_WALK) && active;
	assign rd_addr      = node_m1[AW-1:0];
	assign wr_addr      = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign ctl.clr_we   = (state_q == ST_CLEAR);
	assign ctl.proc_s1  = proc_s1;
	assign ctl.is_query = is_query_q;
	assign ctl.fin      = fin;

endmodule

`default_nettype wire

// ===== rtl/fenwick_prefix_sum_tree.sv =====
// Walk: an update or query visiting L tree nodes keeps busy high from the
// accepting edge until its walk ends; a query result strobes in the cycle
// after busy falls. L is at most log2(SIZE)+1 (13 at SIZE 4096):
// one node read per cycle through the single read port of the node memory.
// A new request is accepted only once busy is low again.
// Reset: a clearing pass zeroes all SIZE nodes with busy high.
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_tree
// Binary indexed tree of 32-bit counters: signed point updates and prefix
// sum queries, state held in one synchronous RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_prefix_sum_tree #(
	parameter int SIZE = fpst_pkg::SIZE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                req_type,
	input  wire logic        [fpst_pkg::POS_W-1:0]   position,
	input  wire logic signed [fpst_pkg::DELTA_W-1:0] delta,
	output logic                                     done,
	output logic signed      [fpst_pkg::SUM_W-1:0]   prefix_total
);

	import fpst_pkg::*;

	localparam int AW = $clog2(SIZE);

	walk_ctl_t            ctl;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [SUM_W-1:0]     rdata;
	logic [SUM_W-1:0]     wdata;
	logic                 we;
	logic                 accept;

	// request payload held for the walk
	logic [DELTA_W-1:0]   delta_q;
	logic [SUM_W-1:0]     acc_q;
	logic                 done_q;
	logic [SUM_W-1:0]     total_q;
	logic [SUM_W-1:0]     delta_ext;

	assign accept    = start && !busy;
	assign delta_ext = {{(SUM_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};

	fpst_walk #(
		.SIZE (SIZE)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.position (position),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.ctl      (ctl)
	);

	// Update: read-modify-write, one node per cycle. Nodes on one walk are
	// distinct, and a new request is taken only after the last write, so no
	// read ever meets a pending write to the same entry.
	assign we    = ctl.clr_we || (ctl.proc_s1 && !ctl.is_query);
	assign wdata = ctl.clr_we ? '0 : (rdata + delta_ext);

	fpst_ram #(
		.WIDTH (SUM_W),
		.DEPTH (SIZE)
	) u_nodes (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= delta;
		end
	end

	// query accumulator, wraps at 32 bits
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= '0;
		end else if (ctl.proc_s1 && ctl.is_query) begin
			acc_q <= acc_q + rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin && ctl.is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			total_q <= acc_q;
		end
	end

	assign done         = done_q;
	assign prefix_total = total_q;

endmodule

`default_nettype wire

// ===== rtl/fpst_checker.sv =====
// ----------------------------------------------------------------------------
// fpst_checker
// Port-level checks for the prefix-sum tree, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// a result closes a request that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe outside end of request");

	// at most one result per request
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// a request cannot finish in the cycle right after it is accepted
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe too early");

endmodule

bind fenwick_prefix_sum_tree fpst_checker u_fpst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

// ===== tb/tb_fenwick_prefix_sum_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenwick_prefix_sum_tree
// Self-checking bench for the prefix-sum tree. A flat array of entries
// predicts every query total. Stimulus runs in this order: directed corner
// requests, a short root-only update burst, and then random request phases
// with and without sender idling.
// ----------------------------------------------------------------------------

module tb_fenwick_prefix_sum_tree;

	import fpst_pkg::*;

	// Tracks the entries as plain values (not tree nodes) and queues the
	// prefix totals that queries must return, in request order.
	class prefix_sum_tracker;
		bit [SUM_W-1:0]          entry_val [1:SIZE_DEF];
		logic signed [SUM_W-1:0] expected_totals [$];
		int                      fault_count;

		function void note_request(logic kind, logic [POS_W-1:0] pos,
				logic signed [DELTA_W-1:0] amt);
			bit [SUM_W-1:0] acc;
			int             last;
			if (kind == REQ_ADD) begin
				// position zero and positions past the last entry are dropped
				if (pos != 0 && pos <= SIZE_DEF)
					entry_val[pos] += {{(SUM_W-DELTA_W){amt[DELTA_W-1]}}, amt};
			end else begin
				acc  = '0;
				last = (pos > SIZE_DEF) ? SIZE_DEF : int'(pos);
				for (int i = 1; i <= last; i++)
					acc += entry_val[i];
				expected_totals.push_back(acc);
			end
		endfunction

		function void check_total(logic signed [SUM_W-1:0] got);
			logic signed [SUM_W-1:0] want;
			if (expected_totals.size() == 0) begin
				$error("prefix_total: expected none, actual %0d", got);
				fault_count++;
			end else begin
				want = expected_totals.pop_front();
				if (got !== want) begin
					$error("prefix_total: expected %0d, actual %0d", want, got);
					fault_count++;
				end
			end
		endfunction

		function void close_out();
			if (expected_totals.size() != 0) begin
				$error("prefix_total: expected %0d more results, actual 0",
					expected_totals.size());
				fault_count++;
			end
		endfunction
	endclass

	localparam real HALF_PERIOD = 2.0;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        start        = 1'b0;
	logic                        req_type     = REQ_ADD;
	logic        [POS_W-1:0]     position     = '0;
	logic signed [DELTA_W-1:0]   delta        = '0;
	logic                        busy;
	logic                        done;
	logic signed [SUM_W-1:0]     prefix_total;

	prefix_sum_tracker board;

	always #(HALF_PERIOD) clk = ~clk;

	fenwick_prefix_sum_tree dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.position     (position),
		.delta        (delta),
		.done         (done),
		.prefix_total (prefix_total)
	);

	// Results cannot be held off: sample the strobe on every edge. Outputs
	// are registered, so reads here see the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0)
			board.check_total(prefix_total);
	end

	// Present one request and hold it until an edge sees start high with
	// busy low. With idling on, start drops for a random stretch first, so
	// the gaps land anywhere in the previous walk or after it.
	task automatic issue_request(input logic kind, input logic [POS_W-1:0] pos,
			input logic signed [DELTA_W-1:0] amt, input int idle_pct);
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(20, 1);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		position <= pos;
		delta    <= amt;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(kind, pos, amt);
	endtask

	// Random position: mostly inside the tree, with position zero, the last
	// entry and the out-of-range upper half (top of the 13 bits set) all common.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		else if (r < 18)
			return POS_W'($urandom_range(8191, SIZE_DEF + 1));
		else if (r < 24)
			return POS_W'(SIZE_DEF);
		else if (r < 34)
			return POS_W'($urandom_range(16, 1));
		return POS_W'($urandom_range(SIZE_DEF, 1));
	endfunction

	function automatic logic signed [DELTA_W-1:0] pick_delta();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'sh7fff;
		else if (r < 10)
			return 16'sh8000;
		return DELTA_W'($urandom);
	endfunction

	initial begin
		int idle_plan [4];
		int guard;
		board = new;
		idle_plan = '{0, 48, 18, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners. The first request also waits out the clearing
		// pass, since busy stays high until every node is zeroed.
		issue_request(REQ_QUERY, 13'd0,    16'sd0,    0); // empty prefix on a clear tree
		issue_request(REQ_QUERY, 13'd4096, 16'sd0,    0);
		issue_request(REQ_QUERY, 13'd8191, 16'sd0,    0);
		issue_request(REQ_ADD,   13'd0,    16'sd12345, 0); // dropped
		issue_request(REQ_QUERY, 13'd0,    16'sh7fff, 0);
		issue_request(REQ_ADD,   13'd1,    16'sh7fff, 0); // longest upward walk
		issue_request(REQ_ADD,   13'd4096, 16'sh8000, 0);
		issue_request(REQ_ADD,   13'd4097, 16'sd1000, 0); // past the end: dropped
		issue_request(REQ_ADD,   13'd8191, -16'sd1,   0); // past the end: dropped
		issue_request(REQ_ADD,   13'd2048, -16'sd1,   0);
		issue_request(REQ_ADD,   13'd4095, 16'sd1,    0);
		issue_request(REQ_QUERY, 13'd1,    16'sh8000, 0); // delta ignored on query
		issue_request(REQ_QUERY, 13'd2047, 16'sd0,    0);
		issue_request(REQ_QUERY, 13'd2048, 16'sd0,    0);
		issue_request(REQ_QUERY, 13'd4095, 16'sd0,    0); // longest downward walk
		issue_request(REQ_QUERY, 13'd4096, 16'sd0,    0);
		issue_request(REQ_QUERY, 13'd4097, 16'sd0,    0); // clamps to the last entry
		issue_request(REQ_QUERY, 13'd8191, 16'sd0,    0);
		issue_request(REQ_ADD,   13'd1,    16'sh8000, 0);
		issue_request(REQ_QUERY, 13'd1,    16'sd0,    0);
		issue_request(REQ_ADD,   13'd5461, 16'sh5555, 0); // alternating bits, dropped
		issue_request(REQ_ADD,   13'd2730, 16'sh5555, 0); // alternating bits
		issue_request(REQ_QUERY, 13'd2730, 16'sd0,    0);
		issue_request(REQ_QUERY, 13'd2731, 16'sd0,    0);

		// Root-only burst: position SIZE touches one node, so each request is
		// a one-node walk, back to back.
		for (int i = 0; i < 16; i++)
			issue_request(REQ_ADD, 13'd4096, 16'sh7fff, 0);
		issue_request(REQ_QUERY, 13'd4096, 16'sd0, 0);
		issue_request(REQ_QUERY, 13'd8191, 16'sd0, 0);
		issue_request(REQ_QUERY, 13'd4095, 16'sd0, 0);

		// Random phases, half queries and half updates
		foreach (idle_plan[p]) begin
			for (int i = 0; i < 313; i++)
				issue_request(logic'($urandom_range(1)), pick_position(),
					pick_delta(), idle_plan[p]);
		end
		start <= 1'b0;

		// Drain: outstanding totals, then room for a final walk with no result
		guard = 0;
		while (board.expected_totals.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		board.close_out();

		if (board.fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== fenwick_prefix_sum_tree.f =====
rtl/fpst_pkg.sv
rtl/fpst_ram.sv
rtl/fpst_walk.sv
rtl/fenwick_prefix_sum_tree.sv
rtl/fpst_checker.sv
tb/tb_fenwick_prefix_sum_tree.sv
